// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the slot pool modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define SPOOL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SPOOL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPOOL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spool_pkg.sv =====
// ----------------------------------------------------------------------------
// spool_pkg
// types and constants of the slot pool allocator
// ----------------------------------------------------------------------------
package spool_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // request kinds
  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_NEXT  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_NOT_IN_USE = 2'd3
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch request word and issue pointer reads
    logic commit;   // apply list updates and load the result register
  } cmd_t;

endpackage

// ===== rtl/spool_ctrl.sv =====
// ----------------------------------------------------------------------------
// spool_ctrl
// request sequencer: accept, then commit once the result register is free
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spool_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output spool_pkg::cmd_t cmd
);
  import spool_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // handshake and command decode
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    cmd.capture = in_ready && in_valid;
    cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  end

  // next state and result valid
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `SPOOL_ASSERT_NXT(a_commit_shows_result, cmd.commit, out_valid_r, "commit did not raise result valid")
  `SPOOL_ASSERT_NXT(a_exec_holds, (state_r == S_EXEC) && !cmd.commit, (state_r == S_EXEC) && !in_ready, "request left execute without commit")

endmodule

// ===== rtl/spool_dp.sv =====
// ----------------------------------------------------------------------------
// spool_dp
// pointer memories, list registers, in-use flags and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spool_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  spool_pkg::cmd_t  cmd,
  input  logic [1:0]       in_kind,
  input  spool_pkg::slot_t in_slot_index,
  output logic [1:0]       out_status,
  output spool_pkg::slot_t out_result_slot,
  output spool_pkg::cnt_t  out_used_count
);
  import spool_pkg::*;

  // pointer memories
  slot_t free_next_mem [SLOTS];
  slot_t used_next_mem [SLOTS];
  slot_t used_prev_mem [SLOTS];

  // free_next entries not yet written read as their reset link
  logic [SLOTS-1:0] fn_vld_r, fn_vld_nxt;

  // list and cursor registers
  slot_t free_head_r, free_head_nxt;
  slot_t free_tail_r, free_tail_nxt;
  slot_t used_head_r, used_head_nxt;
  slot_t used_tail_r, used_tail_nxt;
  slot_t cursor_r, cursor_nxt;
  cnt_t  count_r, count_nxt;
  logic [SLOTS-1:0] in_use_r, in_use_nxt;

  // captured request word
  kind_t kind_r;
  slot_t slot_r;

  // registered memory read data
  slot_t fn_rd_r;
  logic  fn_vld_rd_r;
  slot_t un_rd_r;
  slot_t up_rd_r;

  // memory write ports
  logic  fn_we, un_we, up_we;
  slot_t fn_waddr, un_waddr, up_waddr;
  slot_t fn_wdata, un_wdata, up_wdata;

  // read addresses
  slot_t un_raddr;

  // result payload
  status_t res_status;
  slot_t   res_slot;
  status_t out_status_r;
  slot_t   out_slot_r;
  cnt_t    out_count_r;

  // successor of the free head, with the reset link for unwritten entries
  cnt_t  fn_inc;
  slot_t fn_eff;

  assign fn_inc = cnt_t'(free_head_r) + cnt_t'(1);
  assign fn_eff = fn_vld_rd_r ? fn_rd_r :
                  ((fn_inc >= cnt_t'(SLOTS)) ? '0 : slot_t'(fn_inc));

  // free and get-next follow the link of their own slot
  assign un_raddr = (kind_t'(in_kind) == KIND_FREE) ? in_slot_index : cursor_r;

  // request word capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind_t'(in_kind);
      slot_r <= in_slot_index;
    end
  end

  // free_next memory
  always_ff @(posedge clk) begin
    if (fn_we) begin
      free_next_mem[fn_waddr] <= fn_wdata;
    end
    if (cmd.capture) begin
      fn_rd_r     <= free_next_mem[free_head_r];
      fn_vld_rd_r <= fn_vld_r[free_head_r];
    end
  end

  // used_next memory
  always_ff @(posedge clk) begin
    if (un_we) begin
      used_next_mem[un_waddr] <= un_wdata;
    end
    if (cmd.capture) begin
      un_rd_r <= used_next_mem[un_raddr];
    end
  end

  // used_prev memory
  always_ff @(posedge clk) begin
    if (up_we) begin
      used_prev_mem[up_waddr] <= up_wdata;
    end
    if (cmd.capture) begin
      up_rd_r <= used_prev_mem[in_slot_index];
    end
  end

  // list update for the captured request
  always_comb begin
    free_head_nxt = free_head_r;
    free_tail_nxt = free_tail_r;
    used_head_nxt = used_head_r;
    used_tail_nxt = used_tail_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    in_use_nxt    = in_use_r;
    fn_vld_nxt    = fn_vld_r;
    fn_we         = 1'b0;
    fn_waddr      = '0;
    fn_wdata      = '0;
    un_we         = 1'b0;
    un_waddr      = '0;
    un_wdata      = '0;
    up_we         = 1'b0;
    up_waddr      = '0;
    up_wdata      = '0;
    res_status    = ST_OK;
    res_slot      = '0;
    if (cmd.commit) begin
      case (kind_r)
        KIND_ALLOC: begin
          if (count_r >= cnt_t'(SLOTS)) begin
            res_status = ST_EXHAUSTED;
          end else begin
            // take the free head, append it to the in-use tail
            if (count_r < cnt_t'(SLOTS - 1)) begin
              free_head_nxt = fn_eff;
            end
            if (count_r == '0) begin
              used_head_nxt = free_head_r;
              used_tail_nxt = free_head_r;
              cursor_nxt    = free_head_r;
            end else begin
              un_we         = 1'b1;
              un_waddr      = used_tail_r;
              un_wdata      = free_head_r;
              up_we         = 1'b1;
              up_waddr      = free_head_r;
              up_wdata      = used_tail_r;
              used_tail_nxt = free_head_r;
            end
            in_use_nxt[free_head_r] = 1'b1;
            count_nxt = count_r + cnt_t'(1);
            res_slot  = free_head_r;
          end
        end
        KIND_FREE: begin
          if (!in_use_r[slot_r]) begin
            res_status = ST_NOT_IN_USE;
          end else begin
            count_nxt = count_r - cnt_t'(1);
            // move the cursor off the freed slot, clear it when empty
            if (count_r == cnt_t'(1)) begin
              cursor_nxt = '0;
            end else if (cursor_r == slot_r) begin
              cursor_nxt = (slot_r == used_tail_r) ? used_head_r : un_rd_r;
            end
            // unlink from the in-use list
            if (slot_r == used_head_r && slot_r == used_tail_r) begin
              used_head_nxt = '0;
              used_tail_nxt = '0;
            end else if (slot_r == used_head_r) begin
              used_head_nxt = un_rd_r;
            end else if (slot_r == used_tail_r) begin
              used_tail_nxt = up_rd_r;
            end else begin
              un_we    = 1'b1;
              un_waddr = up_rd_r;
              un_wdata = un_rd_r;
              up_we    = 1'b1;
              up_waddr = un_rd_r;
              up_wdata = up_rd_r;
            end
            // append to the free tail
            if (count_r >= cnt_t'(SLOTS)) begin
              free_head_nxt = slot_r;
            end else begin
              fn_we                   = 1'b1;
              fn_waddr                = free_tail_r;
              fn_wdata                = slot_r;
              fn_vld_nxt[free_tail_r] = 1'b1;
            end
            free_tail_nxt      = slot_r;
            in_use_nxt[slot_r] = 1'b0;
          end
        end
        KIND_NEXT: begin
          if (count_r == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_slot   = cursor_r;
            cursor_nxt = (cursor_r == used_tail_r) ? used_head_r : un_rd_r;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      free_tail_r <= slot_t'(SLOTS - 1);
      used_head_r <= '0;
      used_tail_r <= '0;
      cursor_r    <= '0;
      count_r     <= '0;
      in_use_r    <= '0;
      fn_vld_r    <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      free_tail_r <= free_tail_nxt;
      used_head_r <= used_head_nxt;
      used_tail_r <= used_tail_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      in_use_r    <= in_use_nxt;
      fn_vld_r    <= fn_vld_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_count_r  <= count_nxt;
    end
  end

  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;
  assign out_used_count  = out_count_r;

  // checks
  `SPOOL_ASSERT(a_count_range, count_r <= cnt_t'(SLOTS), "in-use count above pool size")
  `SPOOL_ASSERT(a_count_flags, count_r == cnt_t'($countones(in_use_r)), "in-use count disagrees with flags")
  `SPOOL_ASSERT_IMP(a_empty_cursor, count_r == '0, cursor_r == '0, "cursor not cleared on empty pool")

endmodule

// ===== rtl/slot_pool_with_round_robin_cursor.sv =====
// accept to result valid: pointer memories are read at accept, then list update and result register load at commit
// a new request is accepted only after the previous one has committed, because the registered read of the
//   free_next/used_next/used_prev memories comes ahead of the list update
// a waiting result stalls only the commit cycle; the output register holds it
// reset: synchronous active low, lists and cursor restored without a clearing pass
// ----------------------------------------------------------------------------
// slot_pool_with_round_robin_cursor
// slot allocator over a FIFO free list and an in-use list with round-robin cursor
// ----------------------------------------------------------------------------

module slot_pool_with_round_robin_cursor (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_kind,
  input  spool_pkg::slot_t in_slot_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output spool_pkg::slot_t out_result_slot,
  output spool_pkg::cnt_t  out_used_count
);
  import spool_pkg::*;

  cmd_t cmd;

  // request sequencer
  spool_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // list datapath
  spool_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_slot_index   (in_slot_index),
    .out_status      (out_status),
    .out_result_slot (out_result_slot),
    .out_used_count  (out_used_count)
  );

endmodule
